/* hw/rtl/ftcpu_pkg.sv */
// Package for the four-register toy CPU execute block.
// Holds the operation codes and the field widths; depends on nothing else.
package ftcpu_pkg;

  localparam int unsigned DataW             = 32;
  localparam int unsigned PcW               = 8;
  localparam int unsigned TgtW              = 7;
  localparam int unsigned LenW              = 8;
  localparam int unsigned NumRegs           = 4;
  localparam int unsigned RegIdxW           = 2;
  localparam int unsigned ProgramDepthDef   = 128;

  // Pre-decoded operation codes; the one code left over behaves as nop.
  typedef enum logic [3:0] {
    CMD_NOP   = 4'd0,
    CMD_READ  = 4'd1,
    CMD_PRINT = 4'd2,
    CMD_MOV   = 4'd3,
    CMD_ADD   = 4'd4,
    CMD_SUB   = 4'd5,
    CMD_MUL   = 4'd6,
    CMD_DIV   = 4'd7,
    CMD_JMP   = 4'd8,
    CMD_JE    = 4'd9,
    CMD_JNE   = 4'd10,
    CMD_JG    = 4'd11,
    CMD_JGE   = 4'd12,
    CMD_JL    = 4'd13,
    CMD_JLE   = 4'd14
  } cmd_e;

  typedef logic signed [DataW-1:0] word_t;

endpackage

/* hw/rtl/four_register_toy_cpu_execute_top.sv */
// Execute stage of a four-register toy CPU: register file, program counter and
// a shared iterative multiply/divide unit. Depends on ftcpu_pkg.
// A word is captured in the idle state and executed in the exec state; mul and div
// then run the 32 steps of the shared shift-add / restoring-divide unit. Every result
// waits for a free result register, and no new word is taken before it is loaded.
// Reset (asynchronous, active low) clears the registers, the pc and program_length.
module four_register_toy_cpu_execute_top #(
  parameter int unsigned PROGRAM_DEPTH = ftcpu_pkg::ProgramDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration
  input  logic                               cfg_we_i,
  input  logic [ftcpu_pkg::LenW-1:0]         cfg_wdata_i,
  // Instruction input
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [3:0]                         cmd_i,
  input  logic                               src_is_imm_i,
  input  logic [ftcpu_pkg::RegIdxW-1:0]      src_reg_i,
  input  logic signed [ftcpu_pkg::DataW-1:0] src_imm_i,
  input  logic                               dst_is_imm_i,
  input  logic [ftcpu_pkg::RegIdxW-1:0]      dst_reg_i,
  input  logic signed [ftcpu_pkg::DataW-1:0] dst_imm_i,
  input  logic [ftcpu_pkg::TgtW-1:0]         branch_target_i,
  input  logic signed [ftcpu_pkg::DataW-1:0] read_value_i,
  // Result output
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [ftcpu_pkg::PcW-1:0]          next_pc_o,
  output logic                               halted_o,
  output logic                               print_valid_o,
  output logic signed [ftcpu_pkg::DataW-1:0] print_value_o,
  output logic                               divide_error_o
);
  import ftcpu_pkg::*;

  localparam logic [PcW:0] DepthLim = (PcW+1)'(PROGRAM_DEPTH);
  localparam int unsigned  CntW     = $clog2(DataW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ITER,
    ST_FIN
  } state_e;

  state_e               state_q;
  logic [LenW-1:0]      plen_q;
  logic [PcW-1:0]       pc_q;
  word_t                gp_q [NumRegs];
  word_t                xr_q, yr_q;

  // Captured instruction word
  logic [3:0]           cmd_q;
  logic                 src_is_imm_q, dst_is_imm_q;
  logic [RegIdxW-1:0]   src_reg_q, dst_reg_q;
  word_t                src_imm_q, dst_imm_q, rdval_q;
  logic [TgtW-1:0]      tgt_q;

  // Iterative unit state
  logic [DataW-1:0]     acc_q, opa_q, opb_q;
  logic [CntW-1:0]      cnt_q;
  logic                 div_q, neg_q;

  logic                 out_valid_q, halted_q, pvalid_q, derr_q;
  logic [PcW-1:0]       npc_out_q;
  word_t                pval_q;

  logic                 out_free;
  logic                 res_load;
  logic [PcW:0]         len_lim;
  word_t                x, y;
  logic                 halt_now;
  logic                 take;
  logic [PcW-1:0]       npc;
  logic                 ex_wr;
  logic [RegIdxW-1:0]   ex_wr_idx;
  word_t                ex_wr_data;
  logic                 ex_pvalid, ex_derr, ex_start;
  logic [DataW-1:0]     x_mag, y_mag;
  logic [DataW:0]       add_a, add_b;
  logic [DataW+1:0]     add_s;
  word_t                fin_res;
  logic [PcW-1:0]       pc_inc;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;

  // A result is loaded this cycle from execution or from the iterative unit.
  assign res_load = out_free && (((state_q == ST_EXEC) && !(!halt_now && ex_start)) ||
                                 (state_q == ST_FIN));

  // Effective program length, limited by the program store depth.
  always_comb begin
    len_lim = ({1'b0, plen_q} < DepthLim) ? {1'b0, plen_q} : DepthLim;
  end

  // Operand selection and the combinational part of execution.
  always_comb begin
    x          = src_is_imm_q ? src_imm_q : xr_q;
    y          = dst_is_imm_q ? dst_imm_q : yr_q;
    halt_now   = ({1'b0, pc_q} >= len_lim);
    pc_inc     = pc_q + PcW'(1);
    take       = 1'b0;
    ex_wr      = 1'b0;
    ex_wr_idx  = dst_reg_q;
    ex_wr_data = x;
    ex_pvalid  = 1'b0;
    ex_derr    = 1'b0;
    ex_start   = 1'b0;
    unique case (cmd_e'(cmd_q))
      CMD_READ: begin
        ex_wr      = !src_is_imm_q;
        ex_wr_idx  = src_reg_q;
        ex_wr_data = rdval_q;
      end
      CMD_PRINT: ex_pvalid = 1'b1;
      CMD_MOV: begin
        ex_wr      = !dst_is_imm_q;
        ex_wr_data = x;
      end
      CMD_ADD: begin
        ex_wr      = !dst_is_imm_q;
        ex_wr_data = y + x;
      end
      CMD_SUB: begin
        ex_wr      = !dst_is_imm_q;
        ex_wr_data = y - x;
      end
      CMD_MUL: ex_start = !dst_is_imm_q;
      CMD_DIV: begin
        ex_derr  = !dst_is_imm_q && (y == '0);
        ex_start = !dst_is_imm_q && (y != '0);
      end
      CMD_JMP: take = 1'b1;
      CMD_JE:  take = (x == y);
      CMD_JNE: take = (x != y);
      CMD_JG:  take = (y < x);
      CMD_JGE: take = !(x < y);
      CMD_JL:  take = (x < y);
      CMD_JLE: take = !(y < x);
      default: ;
    endcase
    npc   = take ? {1'b0, tgt_q} : pc_inc;
    x_mag = x[DataW-1] ? (DataW)'(-x) : (DataW)'(x);
    y_mag = y[DataW-1] ? (DataW)'(-y) : (DataW)'(y);
  end

  // Shared adder: accumulate for multiply, trial subtract for divide.
  always_comb begin
    if (div_q) begin
      add_a = {acc_q, opb_q[DataW-1]};
      add_b = {1'b0, opa_q};
    end else begin
      add_a = {1'b0, acc_q};
      add_b = {1'b0, (opb_q[0] ? opa_q : '0)};
    end
    add_s   = {1'b0, add_a} + {1'b0, add_b ^ {(DataW+1){div_q}}} + (DataW+2)'(div_q);
    fin_res = div_q ? (neg_q ? word_t'(-opb_q) : word_t'(opb_q)) : word_t'(acc_q);
  end

  // Sequencer, register file, pc and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      plen_q       <= '0;
      pc_q         <= '0;
      for (int i = 0; i < NumRegs; i++) gp_q[i] <= '0;
      xr_q         <= '0;
      yr_q         <= '0;
      cmd_q        <= '0;
      src_is_imm_q <= 1'b0;
      dst_is_imm_q <= 1'b0;
      src_reg_q    <= '0;
      dst_reg_q    <= '0;
      src_imm_q    <= '0;
      dst_imm_q    <= '0;
      rdval_q      <= '0;
      tgt_q        <= '0;
      acc_q        <= '0;
      opa_q        <= '0;
      opb_q        <= '0;
      cnt_q        <= '0;
      div_q        <= 1'b0;
      neg_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      npc_out_q    <= '0;
      halted_q     <= 1'b0;
      pvalid_q     <= 1'b0;
      pval_q       <= '0;
      derr_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        plen_q <= cfg_wdata_i;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          // Capture the word and read both operand registers.
          if (in_valid_i && in_ready_o) begin
            cmd_q        <= cmd_i;
            src_is_imm_q <= src_is_imm_i;
            dst_is_imm_q <= dst_is_imm_i;
            src_reg_q    <= src_reg_i;
            dst_reg_q    <= dst_reg_i;
            src_imm_q    <= src_imm_i;
            dst_imm_q    <= dst_imm_i;
            rdval_q      <= read_value_i;
            tgt_q        <= branch_target_i;
            xr_q         <= gp_q[src_reg_i];
            yr_q         <= gp_q[dst_reg_i];
            state_q      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (!halt_now && ex_start) begin
            // Hand mul and div to the iterative unit.
            pc_q    <= npc;
            div_q   <= (cmd_e'(cmd_q) == CMD_DIV);
            neg_q   <= x[DataW-1] ^ y[DataW-1];
            acc_q   <= '0;
            cnt_q   <= CntW'(DataW - 1);
            state_q <= ST_ITER;
            if (cmd_e'(cmd_q) == CMD_DIV) begin
              opa_q <= y_mag;
              opb_q <= x_mag;
            end else begin
              opa_q <= DataW'(x);
              opb_q <= DataW'(y);
            end
          end else if (out_free) begin
            state_q     <= ST_IDLE;
            if (halt_now) begin
              npc_out_q <= pc_q;
              halted_q  <= 1'b1;
              pvalid_q  <= 1'b0;
              pval_q    <= '0;
              derr_q    <= 1'b0;
            end else begin
              pc_q      <= npc;
              npc_out_q <= npc;
              halted_q  <= ({1'b0, npc} >= len_lim);
              pvalid_q  <= ex_pvalid;
              pval_q    <= ex_pvalid ? x : '0;
              derr_q    <= ex_derr;
              if (ex_wr) begin
                gp_q[ex_wr_idx] <= ex_wr_data;
              end
            end
          end
        end
        ST_ITER: begin
          // One step of shift-add multiply or restoring divide.
          if (div_q) begin
            if (add_s[DataW+1]) begin
              acc_q <= add_s[DataW-1:0];
              opb_q <= {opb_q[DataW-2:0], 1'b1};
            end else begin
              acc_q <= add_a[DataW-1:0];
              opb_q <= {opb_q[DataW-2:0], 1'b0};
            end
          end else begin
            acc_q <= add_s[DataW-1:0];
            opa_q <= {opa_q[DataW-2:0], 1'b0};
            opb_q <= {1'b0, opb_q[DataW-1:1]};
          end
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == '0) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Write back the product or quotient once the result register is free.
          if (out_free) begin
            gp_q[dst_reg_q] <= fin_res;
            npc_out_q       <= pc_q;
            halted_q        <= ({1'b0, pc_q} >= len_lim);
            pvalid_q        <= 1'b0;
            pval_q          <= '0;
            derr_q          <= 1'b0;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = npc_out_q;
  assign halted_o       = halted_q;
  assign print_valid_o  = pvalid_q;
  assign print_value_o  = pval_q;
  assign divide_error_o = derr_q;

  // An accepted word always moves on to execution in the next cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_EXEC)
    else $error("accepted word did not reach execution");

  // The iterative unit hands over to write-back after its last step.
  a_iter_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ITER && cnt_q == '0 |=> state_q == ST_FIN)
    else $error("iterative unit overran its step count");

  // A print and a divide error never come from the same word.
  a_print_derr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_error_o |-> !print_valid_o)
    else $error("divide error flagged on a print");

  // Print value is zero unless a print is reported.
  a_print_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !print_valid_o |-> print_value_o == '0)
    else $error("print value set without print");

endmodule

/* tb/tb_four_register_toy_cpu_execute_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the four-register toy CPU execute block.
// Directed table followed by random program phases, checked against a local predictor.
// Depends on ftcpu_pkg and four_register_toy_cpu_execute_top.
module tb_four_register_toy_cpu_execute_top;
  import ftcpu_pkg::*;

  localparam int ProgDepth     = int'(ProgramDepthDef);
  localparam int UsefulWords   = 1230;
  localparam int HoldOffAfter  = 500;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 40;
  localparam int TimeoutCycles = 500_000;
  localparam int MaxReports    = 10;

  // The one command code that the package leaves unnamed; it behaves as nop.
  localparam logic [3:0] CmdUnused = 4'd15;

  typedef struct packed {
    logic [3:0]         cmd;
    logic               src_is_imm;
    logic [RegIdxW-1:0] src_reg;
    word_t              src_imm;
    logic               dst_is_imm;
    logic [RegIdxW-1:0] dst_reg;
    word_t              dst_imm;
    logic [TgtW-1:0]    target;
    word_t              read_value;
  } instr_t;

  typedef struct packed {
    logic [PcW-1:0] next_pc;
    logic           halted;
    logic           print_valid;
    word_t          print_value;
    logic           divide_error;
  } result_t;

  typedef struct {
    int      cfg;
    instr_t  ins;
    bit      typed;
    result_t res;
  } row_t;

  localparam result_t NoCheck = '0;

  // Clock, reset and block ports; all the block's inputs are known from time zero.
  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_we       = 1'b0;
  logic [LenW-1:0]    cfg_wdata    = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [3:0]         cmd          = '0;
  logic               src_is_imm   = 1'b0;
  logic [RegIdxW-1:0] src_reg      = '0;
  word_t              src_imm      = '0;
  logic               dst_is_imm   = 1'b0;
  logic [RegIdxW-1:0] dst_reg      = '0;
  word_t              dst_imm      = '0;
  logic [TgtW-1:0]    target       = '0;
  word_t              read_value   = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [PcW-1:0]     next_pc;
  logic               halted;
  logic               print_valid;
  word_t              print_value;
  logic               divide_error;

  // Predictor state: register file, program counter and program length.
  word_t              reg_file [NumRegs];
  logic [PcW-1:0]     cur_pc   = '0;
  logic [LenW-1:0]    prog_len = '0;

  result_t            expected_results [$];
  row_t               dir_rows [$];
  result_t            got;
  result_t            want;
  int                 mismatches   = 0;
  int                 accepted_cnt = 0;
  int                 useful_cnt   = 0;
  bit                 idle_en      = 1'b1;
  bit                 hold_off     = 1'b0;
  int                 stall_left   = 0;

  four_register_toy_cpu_execute_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (cmd),
    .src_is_imm_i    (src_is_imm),
    .src_reg_i       (src_reg),
    .src_imm_i       (src_imm),
    .dst_is_imm_i    (dst_is_imm),
    .dst_reg_i       (dst_reg),
    .dst_imm_i       (dst_imm),
    .branch_target_i (target),
    .read_value_i    (read_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .next_pc_o       (next_pc),
    .halted_o        (halted),
    .print_valid_o   (print_valid),
    .print_value_o   (print_value),
    .divide_error_o  (divide_error)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Effective program length: anything beyond the program depth counts as the depth.
  function automatic int limit_len();
    return (int'(prog_len) > ProgDepth) ? ProgDepth : int'(prog_len);
  endfunction

  function automatic bit model_halted();
    return int'(cur_pc) >= limit_len();
  endfunction

  // Executes one word on the predictor state and returns the result it should produce.
  function automatic result_t execute_instr(input instr_t w);
    result_t        res;
    word_t          x;
    word_t          y;
    word_t          r;
    logic [PcW-1:0] npc;
    bit             take;
    res = '0;
    if (model_halted()) begin
      res.next_pc = cur_pc;
      res.halted  = 1'b1;
      return res;
    end
    x    = w.src_is_imm ? w.src_imm : reg_file[w.src_reg];
    y    = w.dst_is_imm ? w.dst_imm : reg_file[w.dst_reg];
    npc  = cur_pc + 8'd1;
    take = 1'b0;
    case (w.cmd)
      CMD_READ: begin
        if (!w.src_is_imm) reg_file[w.src_reg] = w.read_value;
      end
      CMD_PRINT: begin
        res.print_valid = 1'b1;
        res.print_value = x;
      end
      CMD_MOV, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        // An immediate destination leaves every register alone.
        if (!w.dst_is_imm) begin
          r = y;
          case (w.cmd)
            CMD_MOV: r = x;
            CMD_ADD: r = y + x;
            CMD_SUB: r = y - x;
            CMD_MUL: r = y * x;
            default: begin
              // Zero divisor keeps the register; the most negative over -1 wraps.
              if (y == '0) res.divide_error = 1'b1;
              else if (x == 32'sh8000_0000 && y == -32'sd1) r = x;
              else r = x / y;
            end
          endcase
          reg_file[w.dst_reg] = r;
        end
      end
      CMD_JMP: take = 1'b1;
      CMD_JE:  take = (x == y);
      CMD_JNE: take = (x != y);
      CMD_JG:  take = (y < x);
      CMD_JGE: take = !(x < y);
      CMD_JL:  take = (x < y);
      CMD_JLE: take = !(y < x);
      default: ;
    endcase
    if (take) npc = {1'b0, w.target};
    cur_pc      = npc;
    res.next_pc = cur_pc;
    res.halted  = model_halted();
    return res;
  endfunction

  function automatic instr_t mk(input logic [3:0] c, input bit si, input int sr,
                                input word_t simm, input bit di, input int dr,
                                input word_t dimm, input int tgt, input word_t rd);
    instr_t w;
    w.cmd        = c;
    w.src_is_imm = si;
    w.src_reg    = RegIdxW'(sr);
    w.src_imm    = simm;
    w.dst_is_imm = di;
    w.dst_reg    = RegIdxW'(dr);
    w.dst_imm    = dimm;
    w.target     = TgtW'(tgt);
    w.read_value = rd;
    return w;
  endfunction

  function automatic void add_row(input int cfg, input instr_t ins, input bit typed,
                                  input result_t res);
    row_t r;
    r.cfg   = cfg;
    r.ins   = ins;
    r.typed = typed;
    r.res   = res;
    dir_rows.push_back(r);
  endfunction

  // Operand values biased towards the corners of 32-bit signed arithmetic.
  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = 32'sd1;
      2:       v = -32'sd1;
      3:       v = 32'sh7fff_ffff;
      4:       v = 32'sh8000_0000;
      5:       v = word_t'($urandom_range(0, 15));
      6:       v = -word_t'($urandom_range(1, 15));
      default: v = word_t'($urandom);
    endcase
    return v;
  endfunction

  // Random word shaped to keep the program running: at the last line a jump back
  // is forced nearly always, and always at the full depth so that pc never sticks.
  // When running out, only straight-line words are produced.
  function automatic instr_t random_instr(input bit run_out);
    instr_t w;
    int     lim;
    lim = limit_len();
    if (run_out) begin
      w.cmd = 4'($urandom_range(0, 8));
      if (w.cmd == CMD_JMP) w.cmd = CmdUnused;
    end else begin
      w.cmd = 4'($urandom_range(0, 15));
    end
    w.src_is_imm = 1'($urandom_range(0, 1));
    w.src_reg    = RegIdxW'($urandom_range(0, NumRegs - 1));
    w.src_imm    = pick_operand();
    w.dst_is_imm = 1'($urandom_range(0, 1));
    w.dst_reg    = RegIdxW'($urandom_range(0, NumRegs - 1));
    w.dst_imm    = pick_operand();
    w.read_value = pick_operand();
    if (lim == 0 || $urandom_range(0, 7) == 0) w.target = TgtW'($urandom_range(0, 127));
    else w.target = TgtW'($urandom_range(0, lim - 1));
    if (!run_out && int'(cur_pc) == lim - 1 &&
        (lim == ProgDepth || $urandom_range(0, 9) != 0)) begin
      w.cmd    = CMD_JMP;
      w.target = TgtW'($urandom_range(0, lim - 1));
    end
    return w;
  endfunction

  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic sender_gap();
    if (idle_en && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 3));
  endtask

  // Offers one word, waits for the handshake and records what it should produce.
  task automatic send_word(input instr_t w, input bit typed, input result_t typed_res);
    result_t res;
    @(negedge clk);
    in_valid   <= 1'b1;
    cmd        <= w.cmd;
    src_is_imm <= w.src_is_imm;
    src_reg    <= w.src_reg;
    src_imm    <= w.src_imm;
    dst_is_imm <= w.dst_is_imm;
    dst_reg    <= w.dst_reg;
    dst_imm    <= w.dst_imm;
    target     <= w.target;
    read_value <= w.read_value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = execute_instr(w);
    expected_results.push_back(typed ? typed_res : res);
    accepted_cnt++;
  endtask

  // Program length is only written once the block has drained.
  task automatic write_cfg(input logic [LenW-1:0] v);
    idle_sender(1);
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    prog_len = v;
  endtask

  // One phase of random words; it stops early a few words after the program halts.
  task automatic run_phase(input int n_words, input bit run_out);
    int ignored;
    int budget;
    ignored = 0;
    budget  = $urandom_range(1, 3);
    for (int i = 0; i < n_words; i++) begin
      if (model_halted()) begin
        if (ignored == budget) break;
        ignored++;
      end else begin
        useful_cnt++;
      end
      send_word(random_instr(run_out), 1'b0, NoCheck);
      sender_gap();
    end
  endtask

  // Receiver: short random stalls, plus the long hold-off when requested.
  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Long receiver hold-off while the sender keeps offering words.
  initial begin
    while (accepted_cnt < HoldOffAfter) @(posedge clk);
    hold_off = 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off = 1'b0;
  end

  // Result checker: every accepted word is matched against the oldest expectation.
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      got = '{next_pc, halted, print_valid, print_value, divide_error};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("Unexpected result word: next_pc %0d halted %0b", next_pc, halted);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("Mismatch (exp/got): next_pc %0d/%0d halted %0b/%0b print %0b/%0b",
                     want.next_pc, got.next_pc, want.halted, got.halted,
                     want.print_valid, got.print_valid,
                     " value %0d/%0d div_err %0b/%0b",
                     want.print_value, got.print_value,
                     want.divide_error, got.divide_error);
        end
      end
    end
  end

  // Main sequence.
  initial begin
    foreach (reg_file[i]) reg_file[i] = '0;

    // Directed table: the program length is 0 straight out of reset.
    add_row(-1,  mk(CMD_NOP, 0, 0, '0, 0, 0, '0, 0, '0), 1, '{8'd0, 1'b1, 1'b0, '0, 1'b0});
    add_row(128, mk(CMD_READ, 0, 0, '0, 0, 0, '0, 0, 32'sh7fff_ffff), 0, NoCheck);
    add_row(-1,  mk(CMD_READ, 0, 1, '0, 0, 0, '0, 0, 32'sh8000_0000), 0, NoCheck);
    // A read with an immediate source writes nothing.
    add_row(-1,  mk(CMD_READ, 1, 2, '0, 0, 0, '0, 0, -32'sd1), 0, NoCheck);
    add_row(-1,  mk(CMD_PRINT, 0, 0, '0, 0, 0, '0, 0, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_PRINT, 1, 3, 32'sh8000_0000, 1, 3, '0, 127, '0), 1,
            '{8'd5, 1'b0, 1'b1, 32'sh8000_0000, 1'b0});
    add_row(-1,  mk(CMD_MOV, 1, 0, -32'sd1, 0, 2, '0, 0, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_ADD, 0, 0, '0, 0, 0, '0, 0, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_SUB, 0, 2, '0, 0, 1, '0, 0, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_MUL, 1, 0, -32'sd1, 0, 1, '0, 0, '0), 0, NoCheck);
    // Most negative value over -1 wraps.
    add_row(-1,  mk(CMD_DIV, 1, 0, 32'sh8000_0000, 0, 2, '0, 0, '0), 0, NoCheck);
    // Zero divisor: dx is still clear.
    add_row(-1,  mk(CMD_DIV, 1, 0, 32'sd5, 0, 3, '0, 0, '0), 1,
            '{8'd11, 1'b0, 1'b0, '0, 1'b1});
    // Immediate destinations change nothing and raise no error.
    add_row(-1,  mk(CMD_MOV, 1, 0, -32'sd1, 1, 1, -32'sd1, 0, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_DIV, 1, 0, 32'sd7, 1, 3, '0, 0, '0), 0, NoCheck);
    add_row(-1,  mk(CmdUnused, 0, 1, '0, 0, 2, '0, 99, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_JMP, 0, 0, '0, 0, 0, '0, 127, '0), 1,
            '{8'd127, 1'b0, 1'b0, '0, 1'b0});
    add_row(-1,  mk(CMD_JE, 1, 0, 32'sd5, 1, 0, 32'sd5, 40, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_JNE, 1, 0, 32'sd5, 1, 0, 32'sd5, 10, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_JG, 1, 0, 32'sh7fff_ffff, 1, 0, 32'sh8000_0000, 60, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_JGE, 0, 3, '0, 1, 0, '0, 70, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_JL, 1, 0, 32'sh8000_0000, 1, 0, 32'sh7fff_ffff, 80, '0), 0, NoCheck);
    add_row(-1,  mk(CMD_JLE, 1, 0, 32'sd1, 1, 0, '0, 5, '0), 0, NoCheck);
    // Shorter program: reaching its end halts, and the next word is ignored.
    add_row(82,  mk(CMD_NOP, 0, 0, '0, 0, 0, '0, 0, '0), 1, '{8'd82, 1'b1, 1'b0, '0, 1'b0});
    add_row(-1,  mk(CMD_MOV, 1, 0, 32'sd9, 0, 0, '0, 3, '0), 1,
            '{8'd82, 1'b1, 1'b0, '0, 1'b0});
    // Length beyond the depth resumes execution.
    add_row(255, mk(CMD_JMP, 0, 0, '0, 0, 0, '0, 0, '0), 0, NoCheck);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg >= 0) write_cfg(LenW'(dir_rows[i].cfg));
      send_word(dir_rows[i].ins, dir_rows[i].typed, dir_rows[i].res);
      sender_gap();
    end

    // Random phases, each with its own program length and idling mode.
    while (useful_cnt < UsefulWords) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) write_cfg(LenW'($urandom_range(ProgDepth + 1, 255)));
      else write_cfg(LenW'($urandom_range(int'(cur_pc) + 1, ProgDepth)));
      run_phase($urandom_range(40, 140), 1'b0);
    end

    // Last part without idling: run off the end of a full-depth program.
    idle_en = 1'b0;
    write_cfg(8'd255);
    run_phase(40, 1'b0);
    send_word(mk(CMD_JMP, 0, 0, '0, 0, 0, '0, 118, '0), 1'b0, NoCheck);
    run_phase(14, 1'b1);

    idle_sender(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS four_register_toy_cpu_execute_top");
    end else begin
      $display("FAIL four_register_toy_cpu_execute_top");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TimeoutCycles * 8);
    $display("FAIL four_register_toy_cpu_execute_top");
    $finish;
  end

endmodule
